// ----- src/rmf_pkg.sv -----
`default_nettype none

package rmf_pkg;

    // width of the window length register and its value after reset
    localparam int CFG_BITS     = 9;
    localparam int WINDOW_RESET = 16;

    // item sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE
    } rmf_state_t;

    // divider phases
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_PREP,
        DIV_RUN,
        DIV_SIGN
    } rmf_div_state_t;

endpackage

`default_nettype wire

// ----- src/rmf_ram.sv -----
`default_nettype none

module rmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/rmf_div.sv -----
`default_nettype none

module rmf_div
    import rmf_pkg::*;
#(
    parameter int DIVIDEND_BITS = 24,
    parameter int DIVISOR_BITS  = 9,
    parameter int RESULT_BITS   = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic signed [DIVIDEND_BITS-1:0] dividend,
    input  wire logic        [DIVISOR_BITS-1:0]  divisor,
    output logic                                 valid,
    output logic             [RESULT_BITS-1:0]   quotient
);

    // two quotient bits per cycle, dividend padded to an even width
    localparam int DIV_STEPS = (DIVIDEND_BITS + 1) / 2;
    localparam int DIV_BITS  = 2 * DIV_STEPS;
    localparam int STEP_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    rmf_div_state_t                   state_reg, state_next;
    logic                             valid_reg, valid_next;
    logic        [STEP_BITS-1:0]      step_reg, step_next;
    logic signed [DIVIDEND_BITS-1:0]  dividend_reg, dividend_next;
    logic        [DIVISOR_BITS-1:0]   divisor_reg, divisor_next;
    logic                             neg_reg, neg_next;
    logic        [DIV_BITS-1:0]       quo_reg, quo_next;
    logic        [DIVISOR_BITS-1:0]   rem_reg, rem_next;
    logic        [RESULT_BITS-1:0]    result_reg, result_next;

    logic        [DIVIDEND_BITS-1:0]  magnitude;
    logic        [DIV_BITS-1:0]       quo_step;
    logic        [DIVISOR_BITS-1:0]   rem_step;
    logic        [DIV_BITS-1:0]       quo_neg;

    assign magnitude = dividend_reg[DIVIDEND_BITS-1] ? DIVIDEND_BITS'(-dividend_reg)
                                                     : DIVIDEND_BITS'(dividend_reg);
    assign quo_neg   = DIV_BITS'(~quo_reg + 1'b1);

    // two restoring steps
    always_comb
    begin
        logic [DIVISOR_BITS:0] trial;
        logic [DIV_BITS-1:0]   q;
        logic [DIVISOR_BITS-1:0] r;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < 2; i++)
        begin
            trial = {r, q[DIV_BITS-1]};
            q     = {q[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial = trial - {1'b0, divisor_reg};
                q[0]  = 1'b1;
            end
            r = trial[DIVISOR_BITS-1:0];
        end
        quo_step = q;
        rem_step = r;
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        step_next     = step_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        neg_next      = neg_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        result_next   = result_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    dividend_next = dividend;
                    divisor_next  = divisor;
                    valid_next    = 1'b0;
                    state_next    = DIV_PREP;
                end
            end
            DIV_PREP:
            begin
                neg_next   = dividend_reg[DIVIDEND_BITS-1];
                quo_next   = DIV_BITS'(magnitude);
                rem_next   = '0;
                step_next  = '0;
                state_next = DIV_RUN;
            end
            DIV_RUN:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(DIV_STEPS - 1))
                begin
                    state_next = DIV_SIGN;
                end
            end
            DIV_SIGN:
            begin
                result_next = neg_reg ? quo_neg[RESULT_BITS-1:0] : quo_reg[RESULT_BITS-1:0];
                valid_next  = 1'b1;
                state_next  = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        neg_reg      <= neg_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        result_reg   <= result_next;
    end

    assign valid    = valid_reg;
    assign quotient = result_reg;

endmodule

`default_nettype wire

// ----- src/rolling_mean_filter.sv -----
// rolling_mean_filter: moving average of signed samples over a window of
// window_length samples (1 to WINDOW_MAX; zero acts as one, larger values
// are clamped to WINDOW_MAX).
// channels
//   cfg_valid/cfg_ready + window_length: register write, always ready; a
//     write clears the running sum, fill count and ring position
//   in_valid/in_ready + sample: one item in, one item out
//   out_valid/out_ready + mean: sum of the samples in the window divided
//     by how many have been seen (at most the window), toward zero
// path: ring read at acceptance, update of sum and fill, then the
//   divider's prep, run and sign phases, then the output register
// a new item is taken only once the last mean has gone to the output
//   register; the radix-4 divider takes two quotient bits per cycle; the ring lives
//   in a single-port-write synchronous RAM read once and written once
// in_ready is low while an item is in flight or a cfg write is pending
// a stalled receiver holds mean in the output register; the next item is
//   still taken and waits in the divider until the register frees up
// reset: window length 16, sum, count and position zero; ring entries
//   not yet written in the current window read as zero through the fill
//   count, so no clearing pass is needed
`default_nettype none

module rolling_mean_filter
    import rmf_pkg::*;
#(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_BITS-1:0]    window_length,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [SAMPLE_BITS-1:0] mean
);

    localparam int POS_BITS   = $clog2(WINDOW_MAX);
    localparam int COUNT_BITS = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int CMP_BITS   = (CFG_BITS > COUNT_BITS) ? CFG_BITS : COUNT_BITS;
    localparam int RESET_N    = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

    rmf_state_t                   state_reg, state_next;
    logic        [COUNT_BITS-1:0] window_reg, window_next;
    logic signed [SUM_BITS-1:0]   sum_reg, sum_next;
    logic        [COUNT_BITS-1:0] fill_reg, fill_next;
    logic        [POS_BITS-1:0]   pos_reg, pos_next;
    logic        [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                         out_valid_reg, out_valid_next;
    logic        [SAMPLE_BITS-1:0] mean_reg, mean_next;

    logic                         in_accept;
    logic                         cfg_accept;
    logic        [CMP_BITS-1:0]   cfg_ext;
    logic        [COUNT_BITS-1:0] cfg_window;

    // ring memory
    logic                         ram_we;
    logic        [SAMPLE_BITS-1:0] ram_rdata;

    // update path
    logic                         warming;
    logic        [SAMPLE_BITS-1:0] oldest;
    logic signed [SUM_BITS-1:0]   oldest_ext;
    logic signed [SUM_BITS-1:0]   sample_ext;
    logic        [COUNT_BITS-1:0] pos_inc;

    // divider
    logic                         div_start;
    logic                         div_valid;
    logic        [SAMPLE_BITS-1:0] div_quotient;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign in_accept  = in_valid && in_ready;

    // clamp the written length into 1..WINDOW_MAX
    assign cfg_ext    = CMP_BITS'(window_length);
    assign cfg_window = (cfg_ext == '0) ? COUNT_BITS'(1)
                      : (cfg_ext > CMP_BITS'(WINDOW_MAX)) ? COUNT_BITS'(WINDOW_MAX)
                      : COUNT_BITS'(cfg_ext);

    // an entry not yet written since the last clear reads as zero
    assign warming    = fill_reg < window_reg;
    assign oldest     = warming ? '0 : ram_rdata;
    assign oldest_ext = {{(SUM_BITS - SAMPLE_BITS){oldest[SAMPLE_BITS-1]}}, oldest};
    assign sample_ext = {{(SUM_BITS - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign pos_inc    = COUNT_BITS'(pos_reg) + 1'b1;

    assign ram_we     = (state_reg == ST_UPDATE);
    assign div_start  = (state_reg == ST_UPDATE);

    rmf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .re    (in_accept),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    rmf_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (COUNT_BITS),
        .RESULT_BITS   (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .valid    (div_valid),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg;
        mean_next      = mean_reg;

        // receiver drains the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // ring read of the oldest entry goes out with the accept
                if (in_accept)
                begin
                    sample_next = sample;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // swap oldest for newest, write back, start the divide
                sum_next   = sum_reg - oldest_ext + sample_ext;
                fill_next  = warming ? fill_reg + 1'b1 : fill_reg;
                pos_next   = (pos_inc == window_reg) ? '0 : pos_inc[POS_BITS-1:0];
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_valid && (!out_valid_reg || out_ready))
                begin
                    mean_next      = div_quotient;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a window write restarts the history
        if (cfg_accept)
        begin
            window_next = cfg_window;
            sum_next    = '0;
            fill_next   = '0;
            pos_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= COUNT_BITS'(RESET_N);
            sum_reg       <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        mean_reg   <= mean_next;
    end

    assign out_valid = out_valid_reg;
    assign mean      = mean_reg;

endmodule

`default_nettype wire

// ----- src/rmf_checker.sv -----
`default_nettype none

module rmf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_valid,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [SAMPLE_BITS-1:0] mean
);

    // no item out once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid during reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean))
        else $error("stalled mean changed or dropped");

    // one item in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // a pending window write blocks samples
    a_cfg_first: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> !in_ready)
        else $error("sample taken beside a window write");

    // a new result only appears while the input side is busy
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without an item in flight");

endmodule

bind rolling_mean_filter rmf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);

`default_nettype wire

// ----- verif/rolling_mean_filter_tb.sv -----
`default_nettype none

module rolling_mean_filter_tb;
    import rmf_pkg::*;

    localparam int WINDOW_MAX    = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int CYCLE_LIMIT   = 400000;
    // idle wait after a drain, before a window write or the end of the run
    localparam int SETTLE_CYCLES = 24;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    // opening items at the reset window: rails, sign changes, truncation toward zero
    localparam logic signed [SAMPLE_BITS-1:0] OPENING [20] = '{
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh0000, 16'shFFFF, 16'sh0000, 16'sh0001, 16'shFFFF, 16'shFFFE, 16'sh0003,
        16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh8000
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    wire                    cfg_ready;
    logic [CFG_BITS-1:0]    window_length = '0;
    logic                   in_valid      = 1'b0;
    wire                    in_ready;
    logic [SAMPLE_BITS-1:0] sample        = '0;
    wire                    out_valid;
    logic                   out_ready     = 1'b0;
    wire  [SAMPLE_BITS-1:0] mean;

    // samples waiting to be sent and means waiting to come back
    logic signed [SAMPLE_BITS-1:0] sample_queue [$];
    logic signed [SAMPLE_BITS-1:0] mean_expected [$];

    // window history as the block should hold it
    logic [CFG_BITS-1:0]           window_reg;
    logic signed [SAMPLE_BITS-1:0] hist_ring [WINDOW_MAX];
    longint                        hist_sum;
    int                            hist_fill;
    int                            hist_pos;

    int errors      = 0;
    int cycle_count = 0;

    // sender burst state
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall state
    int hold_left   = 0;
    int steady_left = 0;

    logic signed [SAMPLE_BITS-1:0] exp_mean;

    rolling_mean_filter #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mean          (mean)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // window predictor
    // ---------------------------------------------------------------

    function automatic void wipe_history();
        hist_ring = '{default: '0};
        hist_sum  = 0;
        hist_fill = 0;
        hist_pos  = 0;
    endfunction

    // fold one sample into the window and return the new mean
    function automatic logic signed [SAMPLE_BITS-1:0] fold_sample(
        input logic signed [SAMPLE_BITS-1:0] s
    );
        int     span;
        longint quot;
        // zero acts as one, anything past the ring size is clamped
        if (window_reg == 0)
            span = 1;
        else if (int'(window_reg) > WINDOW_MAX)
            span = WINDOW_MAX;
        else
            span = int'(window_reg);
        if (hist_pos >= span)
            hist_pos = 0;
        if (hist_fill < span)
            hist_fill++;
        // evict the oldest entry, store the new one
        hist_sum = hist_sum - longint'(hist_ring[hist_pos]) + longint'(s);
        hist_ring[hist_pos] = s;
        hist_pos++;
        if (hist_pos >= span)
            hist_pos = 0;
        // integer divide truncates toward zero
        quot = hist_sum / longint'(hist_fill);
        return quot[SAMPLE_BITS-1:0];
    endfunction

    // mix of rails, values near zero and full-range noise
    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_BITS'($urandom_range(0, 8) - 4);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // ---------------------------------------------------------------
    // sample driver: bursts of random length with random gaps
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            // nothing held: either idle or the last item was just taken
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (sample_queue.size() != 0)
            begin
                sample   <= sample_queue.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    // back-to-back bursts now and then
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver: short and long stalls, stretches without any
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (steady_left > 0)
        begin
            steady_left--;
            out_ready <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            case ($urandom_range(0, 11))
                0:       hold_left = $urandom_range(10, 45);
                1, 2, 3: hold_left = $urandom_range(1, 4);
                4:       steady_left = $urandom_range(20, 200);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // monitor: register writes, returned means, accepted samples
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            window_reg = CFG_BITS'(WINDOW_RESET);
            wipe_history();
        end
        else
        begin
            // a write clears the whole history
            if (cfg_valid && cfg_ready)
            begin
                window_reg = window_length;
                wipe_history();
            end
            // check before predicting so a result can never meet its own item
            if (out_valid && out_ready)
            begin
                if (mean_expected.size() == 0)
                begin
                    $error("mean: expected none, actual %0d", $signed(mean));
                    errors++;
                end
                else
                begin
                    exp_mean = mean_expected.pop_front();
                    if ($signed(mean) !== exp_mean)
                    begin
                        $error("mean: expected %0d, actual %0d", exp_mean, $signed(mean));
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                mean_expected.push_back(fold_sample($signed(sample)));
        end
    end

    // hard stop on a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rolling_mean_filter regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic drain();
        while (sample_queue.size() != 0 || in_valid || mean_expected.size() != 0)
            @(posedge clk);
    endtask

    // register write once the block has gone quiet
    task automatic load_window(input logic [CFG_BITS-1:0] w);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid     <= 1'b1;
        window_length <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        repeat (count) sample_queue.push_back(draw_sample());
    endtask

    task automatic queue_run(input logic signed [SAMPLE_BITS-1:0] v, input int count);
        repeat (count) sample_queue.push_back(v);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset window of sixteen, never written yet
        foreach (OPENING[k])
            sample_queue.push_back(OPENING[k]);

        // zero acts as a window of one
        load_window(9'd0);
        queue_random(20);
        load_window(9'd1);
        queue_random(15);
        load_window(9'd2);
        queue_random(20);
        load_window(9'd5);
        queue_random(20);

        // all ones saturates to the full ring
        load_window(9'd511);
        queue_run(SAMPLE_MAX, 40);
        queue_random(10);

        // full ring exactly, sum to its bottom, then wrap with noise
        load_window(9'd256);
        queue_run(SAMPLE_MIN, 256);
        queue_random(10);

        // just past the ring size
        load_window(9'd257);
        queue_random(15);

        load_window(CFG_BITS'($urandom_range(3, 40)));
        queue_random(20);
        load_window(9'd16);
        queue_random(20);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("rolling_mean_filter regression: pass");
        else
            $display("rolling_mean_filter regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- rolling_mean_filter.f -----
src/rmf_pkg.sv
src/rmf_ram.sv
src/rmf_div.sv
src/rolling_mean_filter.sv
src/rmf_checker.sv
verif/rolling_mean_filter_tb.sv
